### rtl/core/assert_macros.svh
// Assertion macros used by the top level of the histogram core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies an expression in the same cycle.
`define ASSERT_SAME(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Check that a condition implies an expression in the next cycle.
`define ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

### rtl/core/cgph_pkg.sv
// Shared types and constants of the chaos-game point histogram core.
package cgph_pkg;

	// Item kinds carried in the slave-side tuser.
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_STEP = 2'd0;
	localparam mode_t MODE_SEED = 2'd1;
	localparam mode_t MODE_READ = 2'd2;

	// Fixed field widths of the stream ports.
	localparam int IN_COORD_W  = 10;
	localparam int OUT_POINT_W = 18;
	localparam int OUT_COUNT_W = 32;
	localparam int S_TDATA_W   = 24;
	localparam int S_TUSER_W   = 2;
	localparam int M_TDATA_W   = 72;
	localparam int M_PAD_W     = M_TDATA_W - 2 * OUT_POINT_W - OUT_COUNT_W;

	// Blend weight register in Q1.16.
	localparam int WEIGHT_W    = 17;
	localparam int WEIGHT_FRAC = 16;
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd32768;

	// Control information that travels with an item down the pipeline.
	typedef struct packed {
		logic  valid;
		mode_t mode;
	} stage_t;

endpackage

### rtl/core/cgph_blend_axis.sv
// Per-axis blend of the current point toward a target vertex.
module cgph_blend_axis
	import cgph_pkg::*;
#(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 8
) (
	input  logic [COORD_BITS+FRAC_BITS-1:0] point,
	input  logic [COORD_BITS-1:0]           target,
	input  logic [WEIGHT_W-1:0]             alpha,
	output logic [COORD_BITS+FRAC_BITS-1:0] next_point
);

	localparam int PT_W   = COORD_BITS + FRAC_BITS;
	localparam int PROD_W = PT_W + 1 + WEIGHT_W + 1;

	logic        [PT_W-1:0]   target_fix;
	logic signed [PT_W:0]     diff;
	logic signed [PROD_W-1:0] prod;

	// The blend p*a + t*(1-a) is rewritten as t + (p-t)*a, which needs a
	// single signed multiplier; the arithmetic shift floors as truncation does.
	always_comb begin
		target_fix = PT_W'(target) << FRAC_BITS;
		diff       = $signed({1'b0, point}) - $signed({1'b0, target_fix});
		prod       = PROD_W'(diff) * PROD_W'($signed({1'b0, alpha}));
		next_point = target_fix + prod[PT_W+WEIGHT_FRAC-1:WEIGHT_FRAC];
	end

endmodule

### rtl/core/cgph_hist_ram.sv
// Histogram memory with one read and one write port and a clearing pass after reset.
module cgph_hist_ram
	import cgph_pkg::*;
#(
	parameter int ADDR_W = 20,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic              clr_busy
);

	logic [DATA_W-1:0] mem [2**ADDR_W];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_busy_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [DATA_W-1:0] mem_wd;

	// Clearing pass: one entry per cycle from address zero to the top.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// The clearing pass owns the write port while it runs.
	always_comb begin
		mem_we = clr_busy_q || wr_en;
		mem_wa = clr_busy_q ? clr_addr_q : wr_addr;
		mem_wd = clr_busy_q ? '0 : wr_data;
	end

	// Write port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	// Registered read port; a read at the address being written returns the old data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

### rtl/core/chaos_game_point_histogram.sv
// Top level of the chaos-game point histogram core.
// The block takes one transaction per clock while s_tready is high and returns its
// result in order through the s1 and s2 stages and the output register. The point
// recurrence is closed in the accept stage by one subtract, multiply and add per axis;
// the histogram lies in a memory with a registered read port and is updated by read,
// increment and write back over two stages, with the last write forwarded so that hits
// on the same cell in successive transactions count correctly. After reset the memory
// of 2^(2*COORD_BITS) cells (1048576 by default) is cleared one cell per cycle, with
// s_tready low meanwhile; writes to the blend weight register are taken at any time.
`include "assert_macros.svh"

module chaos_game_point_histogram
	import cgph_pkg::*;
#(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 8,
	parameter int COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 blend_weight_wr_en,
	input  logic [WEIGHT_W-1:0]  blend_weight_wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // target_x[9:0], target_y[19:10], zero pad
	input  logic [S_TUSER_W-1:0] s_tuser,  // mode[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // point_x[17:0], point_y[35:18],
	                                       // cell_count[67:36], zero pad
);

	localparam int PT_W   = COORD_BITS + FRAC_BITS;
	localparam int ADDR_W = 2 * COORD_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic [WEIGHT_W-1:0]   weight_q;
	logic [WEIGHT_W-1:0]   alpha;
	logic [PT_W-1:0]       cur_x_q, cur_y_q;
	logic [COORD_BITS-1:0] tx, ty;
	mode_t                 in_mode;
	logic [PT_W-1:0]       step_x, step_y;
	logic [PT_W-1:0]       post_x, post_y;
	logic [ADDR_W-1:0]     post_idx;
	logic                  adv, in_acc, clr_busy;

	stage_t                s1_q, s2_q;
	logic [PT_W-1:0]       px_s1, py_s1, px_s2, py_s2;
	logic [ADDR_W-1:0]     idx_s1, idx_s2;

	logic [COUNT_BITS-1:0] rd_data, base, inc, count_s2;
	logic                  wr_en;
	logic                  fwd_valid_q;
	logic [ADDR_W-1:0]     fwd_idx_q;
	logic [COUNT_BITS-1:0] fwd_data_q;

	logic                  m_valid_q;
	mode_t                 m_mode_q;
	logic [PT_W-1:0]       m_px_q, m_py_q;
	logic [COUNT_BITS-1:0] m_count_q;

	// Blend weight register; weights above one are clamped to one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (blend_weight_wr_en) begin
			weight_q <= blend_weight_wr_data;
		end
	end

	assign alpha = (weight_q > WEIGHT_ONE) ? WEIGHT_ONE : weight_q;

	// The pipeline moves whenever the output register is free or being emptied.
	assign adv      = !m_valid_q || m_tready;
	assign s_tready = adv && !clr_busy;
	assign in_acc   = s_tvalid && s_tready;

	assign in_mode = s_tuser;
	assign tx      = COORD_BITS'(s_tdata[IN_COORD_W-1:0]);
	assign ty      = COORD_BITS'(s_tdata[2*IN_COORD_W-1:IN_COORD_W]);

	cgph_blend_axis #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_blend_x (
		.point      (cur_x_q),
		.target     (tx),
		.alpha      (alpha),
		.next_point (step_x)
	);

	cgph_blend_axis #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_blend_y (
		.point      (cur_y_q),
		.target     (ty),
		.alpha      (alpha),
		.next_point (step_y)
	);

	// Point after the transaction and the histogram cell that it touches.
	always_comb begin
		post_x   = cur_x_q;
		post_y   = cur_y_q;
		post_idx = {ty, tx};
		case (in_mode)
			MODE_STEP: begin
				post_x   = step_x;
				post_y   = step_y;
				post_idx = {step_y[PT_W-1:FRAC_BITS], step_x[PT_W-1:FRAC_BITS]};
			end
			MODE_SEED: begin
				post_x = PT_W'(tx) << FRAC_BITS;
				post_y = PT_W'(ty) << FRAC_BITS;
			end
			default: begin
				post_x = cur_x_q;
				post_y = cur_y_q;
			end
		endcase
	end

	// Current point and pipeline control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			s1_q        <= '0;
			s2_q        <= '0;
			fwd_valid_q <= 1'b0;
			m_valid_q   <= 1'b0;
			m_mode_q    <= MODE_STEP;
		end else begin
			if (in_acc) begin
				cur_x_q <= post_x;
				cur_y_q <= post_y;
			end
			if (adv) begin
				s1_q.valid  <= in_acc;
				s1_q.mode   <= in_mode;
				s2_q        <= s1_q;
				fwd_valid_q <= wr_en;
				m_valid_q   <= s2_q.valid;
				m_mode_q    <= s2_q.mode;
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			px_s1      <= post_x;
			py_s1      <= post_y;
			idx_s1     <= post_idx;
			px_s2      <= px_s1;
			py_s2      <= py_s1;
			idx_s2     <= idx_s1;
			fwd_idx_q  <= idx_s2;
			fwd_data_q <= inc;
			m_px_q     <= px_s2;
			m_py_q     <= py_s2;
			m_count_q  <= count_s2;
		end
	end

	cgph_hist_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (COUNT_BITS)
	) u_hist_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (adv),
		.rd_addr  (idx_s1),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (idx_s2),
		.wr_data  (inc),
		.clr_busy (clr_busy)
	);

	// Read, saturating increment and write back, with the previous write forwarded.
	always_comb begin
		base     = (fwd_valid_q && (fwd_idx_q == idx_s2)) ? fwd_data_q : rd_data;
		inc      = (base == COUNT_MAX) ? base : base + 1'b1;
		wr_en    = adv && s2_q.valid && (s2_q.mode == MODE_STEP);
		count_s2 = '0;
		case (s2_q.mode)
			MODE_STEP: count_s2 = inc;
			MODE_READ: count_s2 = base;
			default:   count_s2 = '0;
		endcase
	end

	// Master-side transaction.
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, OUT_COUNT_W'(m_count_q),
		OUT_POINT_W'(m_py_q), OUT_POINT_W'(m_px_q)};

	// A step always leaves a non-zero count in the cell it hits.
	`ASSERT_SAME(a_step_count_nonzero, m_valid_q && (m_mode_q == MODE_STEP), m_count_q != '0, "step result with zero count")
	// A seed clears the fraction bits and reports no count.
	`ASSERT_SAME(a_seed_result, m_valid_q && (m_mode_q == MODE_SEED), (m_count_q == '0) && ((m_px_q & ((PT_W'(1) << FRAC_BITS) - 1'b1)) == '0), "seed result malformed")
	// No transaction is in flight while the memory is being cleared.
	`ASSERT_SAME(a_clear_empty, clr_busy, !s1_q.valid && !s2_q.valid && !m_valid_q, "pipeline busy during clearing pass")
	// A stalled pipeline keeps the stage holding the forwarded write.
	`ASSERT_NEXT(a_stall_hold, !adv, $stable(fwd_valid_q) && $stable(s2_q), "pipeline moved during stall")

endmodule

### tb/chaos_game_point_histogram_tb.sv
// Self-checking testbench for the chaos-game point histogram block.
`timescale 1ns / 1ps

module chaos_game_point_histogram_tb;
	import cgph_pkg::*;

	// The unused item kind: the block ignores it but still answers.
	localparam mode_t MODE_UNUSED = 2'd3;

	localparam int PHASE_COUNT = 8;
	localparam int PHASE_ITEMS = 210;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int HOLD_OFF_AFTER = 300;
	localparam int DRAIN_SETTLE = 4;

	typedef logic [IN_COORD_W-1:0] coord_t;
	typedef logic [2*IN_COORD_W-1:0] cell_t;

	// One expected result: the point after the transaction and the cell count.
	typedef struct {
		logic [OUT_POINT_W-1:0] px;
		logic [OUT_POINT_W-1:0] py;
		logic [OUT_COUNT_W-1:0] count;
	} point_result_t;

	// Tracks the point and the hit histogram, and holds the results still due.
	class chaos_tracker;
		logic [OUT_POINT_W-1:0] cur_x;
		logic [OUT_POINT_W-1:0] cur_y;
		logic [WEIGHT_W-1:0] weight;
		logic [OUT_COUNT_W-1:0] hits[cell_t];
		point_result_t due_q[$];
		cell_t recent[$];
		int failures;

		function new();
			cur_x = '0;
			cur_y = '0;
			weight = WEIGHT_RESET;
			failures = 0;
		endfunction

		function void set_weight(logic [WEIGHT_W-1:0] w);
			weight = w;
		endfunction

		function int outstanding();
			return due_q.size();
		endfunction

		// Weighted blend of one axis in Q10.8, truncated after the Q1.16 product.
		function logic [OUT_POINT_W-1:0] blend(logic [OUT_POINT_W-1:0] p, coord_t t,
				logic [WEIGHT_W-1:0] a);
			logic [63:0] acc;
			acc = 64'(p) * 64'(a) +
				(64'(t) << (OUT_POINT_W - IN_COORD_W)) * (64'(WEIGHT_ONE) - 64'(a));
			return OUT_POINT_W'(acc >> WEIGHT_FRAC);
		endfunction

		function logic [OUT_COUNT_W-1:0] count_of(cell_t idx);
			return hits.exists(idx) ? hits[idx] : '0;
		endfunction

		// Applies one accepted transaction and queues the result it must produce.
		function void accept_item(mode_t mode, coord_t tx, coord_t ty);
			logic [WEIGHT_W-1:0] a;
			logic [OUT_COUNT_W-1:0] count;
			cell_t idx;
			point_result_t r;
			a = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
			count = '0;
			case (mode)
				MODE_STEP: begin
					cur_x = blend(cur_x, tx, a);
					cur_y = blend(cur_y, ty, a);
					idx = {cur_y[OUT_POINT_W-1 -: IN_COORD_W], cur_x[OUT_POINT_W-1 -: IN_COORD_W]};
					count = count_of(idx);
					if (count != '1)
						count = count + 1'b1;
					hits[idx] = count;
					recent.push_back(idx);
					if (recent.size() > 32)
						void'(recent.pop_front());
				end
				MODE_SEED: begin
					cur_x = {tx, {(OUT_POINT_W - IN_COORD_W){1'b0}}};
					cur_y = {ty, {(OUT_POINT_W - IN_COORD_W){1'b0}}};
				end
				MODE_READ: begin
					count = count_of({ty, tx});
				end
				default: begin
				end
			endcase
			r.px = cur_x;
			r.py = cur_y;
			r.count = count;
			due_q.push_back(r);
		endfunction

		// Compares one accepted result with the oldest one still due.
		function void check_result(logic [M_TDATA_W-1:0] data);
			point_result_t r;
			logic [OUT_POINT_W-1:0] px;
			logic [OUT_POINT_W-1:0] py;
			logic [OUT_COUNT_W-1:0] count;
			px = data[OUT_POINT_W-1:0];
			py = data[2*OUT_POINT_W-1:OUT_POINT_W];
			count = data[2*OUT_POINT_W+OUT_COUNT_W-1:2*OUT_POINT_W];
			if (due_q.size() == 0) begin
				$error("unexpected result: point_x %0d point_y %0d cell_count %0d",
					px, py, count);
				failures++;
				return;
			end
			r = due_q.pop_front();
			if (px !== r.px) begin
				$error("point_x: expected %0d, got %0d", r.px, px);
				failures++;
			end
			if (py !== r.py) begin
				$error("point_y: expected %0d, got %0d", r.py, py);
				failures++;
			end
			if (count !== r.count) begin
				$error("cell_count: expected %0d, got %0d", r.count, count);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic blend_weight_wr_en;
	logic [WEIGHT_W-1:0] blend_weight_wr_data;
	logic s_tvalid;
	logic s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	chaos_tracker tracker = new();
	int results_seen = 0;
	int burst_left = 0;
	coord_t vert_x[3];
	coord_t vert_y[3];

	chaos_game_point_histogram dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.blend_weight_wr_en   (blend_weight_wr_en),
		.blend_weight_wr_data (blend_weight_wr_data),
		.s_tvalid             (s_tvalid),
		.s_tready             (s_tready),
		.s_tdata              (s_tdata),
		.s_tuser              (s_tuser),
		.m_tvalid             (m_tvalid),
		.m_tready             (m_tready),
		.m_tdata              (m_tdata)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall time limit, which leaves room for the clearing pass after reset.
	initial begin
		#50_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Checks every result transaction as it is accepted.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tracker.check_result(m_tdata);
			results_seen++;
		end
	end

	// Receiver: stall patterns of varying density, and one long hold-off.
	initial begin
		int style;
		int len;
		bit held_off;
		held_off = 1'b0;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				style = $urandom_range(0, 3);
				len = $urandom_range(10, 80);
				repeat (len) begin
					case (style)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) != 0);
						default: m_tready <= ($urandom_range(0, 4) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Offers one transaction and returns at the edge where it is accepted.
	task automatic send_item(input mode_t mode, input coord_t tx, input coord_t ty);
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {{(S_TDATA_W - 2*IN_COORD_W){1'b0}}, ty, tx};
		do
			@(posedge clk);
		while (!s_tready);
		tracker.accept_item(mode, tx, ty);
	endtask

	// Sender side of the random part: bursts of transactions with gaps between them.
	task automatic send_paced(input mode_t mode, input coord_t tx, input coord_t ty);
		int gap;
		send_item(mode, tx, ty);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Waits until every result has been returned, so that the block is idle.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_SETTLE) @(posedge clk);
	endtask

	task automatic write_weight(input logic [WEIGHT_W-1:0] w);
		blend_weight_wr_en <= 1'b1;
		blend_weight_wr_data <= w;
		@(posedge clk);
		blend_weight_wr_en <= 1'b0;
		tracker.set_weight(w);
	endtask

	// Draws one random transaction: mostly steps towards the phase's vertices, reads that
	// favour recently hit cells so that counts build up, and also seeds and unused kinds.
	task automatic make_item(output mode_t mode, output coord_t tx, output coord_t ty);
		int pick;
		int v;
		cell_t idx;
		pick = $urandom_range(0, 99);
		tx = coord_t'($urandom);
		ty = coord_t'($urandom);
		if (pick < 56) begin
			mode = MODE_STEP;
			if ($urandom_range(0, 9) < 7) begin
				v = $urandom_range(0, 2);
				tx = vert_x[v];
				ty = vert_y[v];
			end
		end else if (pick < 66) begin
			mode = MODE_SEED;
		end else if (pick < 96) begin
			mode = MODE_READ;
			if (tracker.recent.size() > 0 && $urandom_range(0, 9) < 7) begin
				idx = tracker.recent[$urandom_range(0, tracker.recent.size() - 1)];
				tx = idx[IN_COORD_W-1:0];
				ty = idx[2*IN_COORD_W-1:IN_COORD_W];
			end
		end else begin
			mode = MODE_UNUSED;
		end
	endtask

	// Main sequence: reset, directed transactions, then random phases.
	initial begin
		logic [WEIGHT_W-1:0] phase_weight[PHASE_COUNT];
		mode_t mode;
		coord_t tx;
		coord_t ty;
		arst_n <= 1'b0;
		blend_weight_wr_en <= 1'b0;
		blend_weight_wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= MODE_STEP;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset weight of one half; extremes of the coordinates and every item kind.
		// The first transaction waits out the clearing pass of the histogram.
		send_item(MODE_READ, 10'd0, 10'd0);
		send_item(MODE_STEP, 10'd1023, 10'd1023);
		send_item(MODE_STEP, 10'd1023, 10'd1023);
		send_item(MODE_SEED, 10'd1023, 10'd0);
		send_item(MODE_STEP, 10'd0, 10'd1023);
		send_item(MODE_UNUSED, 10'd1023, 10'd1023);
		send_item(MODE_SEED, 10'd0, 10'd0);
		send_item(MODE_READ, 10'd1023, 10'd1023);
		drain();

		// Weight of exactly one: the point stays put and one cell is hit back to back.
		write_weight(WEIGHT_ONE);
		send_item(MODE_SEED, 10'd5, 10'd7);
		send_item(MODE_STEP, 10'd1023, 10'd0);
		send_item(MODE_STEP, 10'd0, 10'd1023);
		send_item(MODE_STEP, 10'd1023, 10'd1023);
		send_item(MODE_READ, 10'd5, 10'd7);
		drain();

		// Weight above one is treated as one.
		write_weight({WEIGHT_W{1'b1}});
		send_item(MODE_STEP, 10'd512, 10'd512);
		send_item(MODE_STEP, 10'd512, 10'd512);
		send_item(MODE_READ, 10'd5, 10'd7);
		drain();

		// Weight of zero: the point jumps to the target.
		write_weight('0);
		send_item(MODE_STEP, 10'd1023, 10'd0);
		send_item(MODE_STEP, 10'd1023, 10'd0);
		send_item(MODE_STEP, 10'd0, 10'd1023);
		send_item(MODE_READ, 10'd1023, 10'd0);
		drain();

		// Smallest non-zero weight.
		write_weight(17'd1);
		send_item(MODE_STEP, 10'd512, 10'd512);
		send_item(MODE_READ, 10'd1023, 10'd1023);
		drain();

		// Random phases, each with its own weight and set of three vertices.
		phase_weight[0] = WEIGHT_RESET;
		phase_weight[1] = '0;
		phase_weight[2] = WEIGHT_ONE;
		phase_weight[3] = {WEIGHT_W{1'b1}};
		phase_weight[4] = WEIGHT_ONE - 1'b1;
		phase_weight[5] = 17'd1;
		phase_weight[6] = WEIGHT_W'($urandom_range(0, 65536));
		phase_weight[7] = WEIGHT_W'($urandom);
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			write_weight(phase_weight[ph]);
			for (int v = 0; v < 3; v++) begin
				vert_x[v] = ($urandom_range(0, 3) == 0) ? {IN_COORD_W{v[0]}} : coord_t'($urandom);
				vert_y[v] = ($urandom_range(0, 3) == 0) ? {IN_COORD_W{v[1]}} : coord_t'($urandom);
			end
			burst_left = $urandom_range(1, 24);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				make_item(mode, tx, ty);
				send_paced(mode, tx, ty);
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (tracker.failures == 0 && tracker.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### chaos_game_point_histogram.f
+incdir+rtl/core
rtl/core/cgph_pkg.sv
rtl/core/cgph_blend_axis.sv
rtl/core/cgph_hist_ram.sv
rtl/core/chaos_game_point_histogram.sv
tb/chaos_game_point_histogram_tb.sv
